// ===== hw/rtl/hwmb_pkg.sv =====
// Package for the hardware mailbox register block: sizes, field widths,
// register word codes and config/event masks. No dependencies.

package hwmb_pkg;

    // Instance count, message words per instance, interrupt lines.
    localparam int NUM_INSTANCES = 32;
    localparam int DATA_WORDS    = 16;
    localparam int INT_LINES     = 16;

    // Transaction field widths.
    localparam int INST_W = 5;
    localparam int WORD_W = 5;
    localparam int DATA_W = 32;
    localparam int IRQ_W  = 16;
    localparam int EVT_W  = 3;

    // Derived storage sizes.
    localparam int MSG_DEPTH   = NUM_INSTANCES * DATA_WORDS;
    localparam int MSG_ADDR_W  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int INST_IDX_W  = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
    localparam int LINE_CNT_W  = $clog2(NUM_INSTANCES + 1);

    // Register word offsets.
    localparam logic [WORD_W-1:0] WORD_CONFIG      = 5'h00;
    localparam logic [WORD_W-1:0] WORD_CAUSE_CLEAR = 5'h01;
    localparam logic [WORD_W-1:0] WORD_STATUS_SET  = 5'h02;
    localparam logic [WORD_W-1:0] WORD_INT_ENABLE  = 5'h03;
    localparam logic [WORD_W-1:0] WORD_DATA        = 5'h04;

    // Config word: owner field in bits 15:8.
    localparam logic [DATA_W-1:0] CFG_OWNER_MASK = 32'h0000_ff00;

    // Event flag bits.
    localparam int EVT_A_BIT = 0;
    localparam int EVT_B_BIT = 1;

    // Access direction.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

endpackage

// ===== hw/rtl/hwmb_if.sv =====
// Valid/ready channel interfaces for the mailbox request and response
// transactions. Depends on hwmb_pkg for field widths.

interface hwmb_req_if;
    import hwmb_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [INST_W-1:0] instance_req;
    logic [WORD_W-1:0] reg_word;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, req_type, instance_req, reg_word, write_data,
                    input ready);
    modport sink   (input valid, req_type, instance_req, reg_word, write_data,
                    output ready);
endinterface

interface hwmb_rsp_if;
    import hwmb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              access_error;
    logic [IRQ_W-1:0]  irq_lines;

    modport source (output valid, read_data, access_error, irq_lines,
                    input ready);
    modport sink   (input valid, read_data, access_error, irq_lines,
                    output ready);
endinterface

// ===== hw/rtl/hwmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old contents.

module hwmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/hw_mailbox_register_block.sv =====
// Top level of the hardware mailbox register block: request decode, per-instance
// state, interrupt line tracking and the response register.
// Depends on hwmb_pkg, hwmb_req_if/hwmb_rsp_if and hwmb_ram.
//
//   Channel  | Dir | Transaction payload
//   ---------+-----+---------------------------------------------------------
//   i_req    | in  | req_type, instance_req, reg_word, write_data
//   o_rsp    | out | read_data, access_error, irq_lines
//
// One request transaction is taken per cycle while i_req.ready is high; its response
// passes through the request register, then the response register.
// After reset the message RAM is swept to zero, one word per cycle, over all
// NUM_INSTANCES*DATA_WORDS words (512 at the default sizes); i_req.ready stays
// low for that sweep. Other control state resets directly; data fields do not.
// A stalled o_rsp holds the response register and the request register behind
// it; i_req.ready drops only once both are full.

module hw_mailbox_register_block (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hwmb_req_if.sink          i_req,
    hwmb_rsp_if.source        o_rsp
);
    import hwmb_pkg::*;

    // Per-instance contribution to the interrupt lines: line k is driven by
    // event A with enable bit 2k, or event B with enable bit 2k+1.
    function automatic logic [INT_LINES-1:0] line_contrib(
        input logic [EVT_W-1:0]  evt,
        input logic [DATA_W-1:0] ien
    );
        logic [INT_LINES-1:0] lines;
        lines = '0;
        for (int k = 0; k < INT_LINES; k++) begin
            lines[k] = (evt[EVT_A_BIT] & ien[2*k]) | (evt[EVT_B_BIT] & ien[2*k+1]);
        end
        return lines;
    endfunction

    // ------------------------------------------------------------------
    // Message RAM clearing sweep after reset
    // ------------------------------------------------------------------
    logic                  r_clearing;
    logic [MSG_ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == MSG_ADDR_W'(MSG_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request register
    // ------------------------------------------------------------------
    logic                  r_s1_valid;
    logic                  r_s1_wr;
    logic                  r_s1_inst_ok;
    logic [INST_IDX_W-1:0] r_s1_inst;
    logic [WORD_W-1:0]     r_s1_word;
    logic [DATA_W-1:0]     r_s1_wdata;
    logic [MSG_ADDR_W-1:0] r_s1_addr;
    logic                  r_byp_hit;
    logic [DATA_W-1:0]     r_byp_data;

    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_rdata;
    logic                  r_out_err;
    logic [IRQ_W-1:0]      r_out_irq;

    logic                  s1_adv;
    logic                  in_accept;
    logic [INST_IDX_W-1:0] in_inst;
    logic [WORD_W-1:0]     in_off;
    logic [MSG_ADDR_W-1:0] in_addr;
    logic                  s1_data_ok;
    logic                  s1_msg_we;
    logic [DATA_W-1:0]     ram_rdata;

    // Advance the request register whenever the response register frees up.
    assign s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_accept = i_req.valid && i_req.ready;

    // Message address from the request port, so the RAM read lines up with
    // the request register.
    assign in_inst = INST_IDX_W'(i_req.instance_req);
    assign in_off  = i_req.reg_word - WORD_DATA;
    assign in_addr = MSG_ADDR_W'(int'(in_inst) * DATA_WORDS + int'(in_off));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_wr      <= i_req.req_type;
            r_s1_inst_ok <= int'(i_req.instance_req) < NUM_INSTANCES;
            r_s1_inst    <= in_inst;
            r_s1_word    <= i_req.reg_word;
            r_s1_wdata   <= i_req.write_data;
            r_s1_addr    <= in_addr;
            // Forward a message write leaving the request register this cycle
            // to a read of the same word entering it; the RAM returns old data.
            r_byp_hit    <= s1_adv && s1_msg_we && (r_s1_addr == in_addr);
            r_byp_data   <= r_s1_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Message RAM
    // ------------------------------------------------------------------
    hwmb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || (s1_adv && s1_msg_we)),
        .i_waddr (r_clearing ? r_clr_addr : r_s1_addr),
        .i_wdata (r_clearing ? '0 : r_s1_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Per-instance state and access decode
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]     r_cfg      [NUM_INSTANCES];
    logic [EVT_W-1:0]      r_evt      [NUM_INSTANCES];
    logic [DATA_W-1:0]     r_ien      [NUM_INSTANCES];
    logic [LINE_CNT_W-1:0] r_line_cnt [INT_LINES];

    logic [DATA_W-1:0]     cur_cfg;
    logic [EVT_W-1:0]      cur_evt;
    logic [DATA_W-1:0]     cur_ien;
    logic [DATA_W-1:0]     n_cfg;
    logic [EVT_W-1:0]      n_evt;
    logic [DATA_W-1:0]     n_ien;
    logic [DATA_W-1:0]     rd_val;
    logic                  acc_err;
    logic [INT_LINES-1:0]  old_lines;
    logic [INT_LINES-1:0]  new_lines;
    logic [LINE_CNT_W-1:0] n_line_cnt [INT_LINES];
    logic [DATA_W-1:0]     n_out_rdata;
    logic [IRQ_W-1:0]      n_out_irq;

    assign s1_data_ok = (r_s1_word >= WORD_DATA) &&
                        (int'(r_s1_word - WORD_DATA) < DATA_WORDS);
    assign s1_msg_we  = r_s1_inst_ok && s1_data_ok && (r_s1_wr == REQ_WRITE);

    assign cur_cfg = r_cfg[r_s1_inst];
    assign cur_evt = r_evt[r_s1_inst];
    assign cur_ien = r_ien[r_s1_inst];

    always_comb begin
        n_cfg   = cur_cfg;
        n_evt   = cur_evt;
        n_ien   = cur_ien;
        rd_val  = '0;
        acc_err = 1'b0;
        if (!r_s1_inst_ok) begin
            acc_err = 1'b1;
        end else begin
            unique case (r_s1_word)
                WORD_CONFIG: begin
                    if (r_s1_wr == REQ_WRITE) begin
                        if ((r_s1_wdata & CFG_OWNER_MASK) == '0) begin
                            // Release: drop config, events and enables.
                            n_cfg = '0;
                            n_evt = '0;
                            n_ien = '0;
                        end else if (((cur_cfg & CFG_OWNER_MASK) == '0) ||
                                     ((cur_cfg & CFG_OWNER_MASK) ==
                                      (r_s1_wdata & CFG_OWNER_MASK))) begin
                            n_cfg = r_s1_wdata;
                        end
                    end else begin
                        rd_val = cur_cfg;
                    end
                end
                WORD_CAUSE_CLEAR: begin
                    if (r_s1_wr == REQ_WRITE) begin
                        n_evt = cur_evt & ~r_s1_wdata[EVT_W-1:0];
                    end else begin
                        rd_val = DATA_W'(cur_evt);
                    end
                end
                WORD_STATUS_SET: begin
                    if (r_s1_wr == REQ_WRITE) begin
                        n_evt = cur_evt | r_s1_wdata[EVT_W-1:0];
                    end else begin
                        rd_val = DATA_W'(cur_evt);
                    end
                end
                WORD_INT_ENABLE: begin
                    if (r_s1_wr == REQ_WRITE) begin
                        n_ien = r_s1_wdata;
                    end else begin
                        rd_val = cur_ien;
                    end
                end
                default: begin
                    if (s1_data_ok) begin
                        rd_val = r_byp_hit ? r_byp_data : ram_rdata;
                    end else begin
                        acc_err = 1'b1;
                    end
                end
            endcase
        end
    end

    // Track, per line, how many instances drive it; adjust by this access only.
    assign old_lines = line_contrib(cur_evt, cur_ien);
    assign new_lines = line_contrib(n_evt, n_ien);

    always_comb begin
        n_out_irq = '0;
        for (int k = 0; k < INT_LINES; k++) begin
            n_line_cnt[k] = r_line_cnt[k] + LINE_CNT_W'(new_lines[k])
                                          - LINE_CNT_W'(old_lines[k]);
            n_out_irq[k]  = n_line_cnt[k] != '0;
        end
    end

    assign n_out_rdata = (r_s1_wr == REQ_WRITE) ? '0 : rd_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_INSTANCES; i++) begin
                r_cfg[i] <= '0;
                r_evt[i] <= '0;
                r_ien[i] <= '0;
            end
            for (int k = 0; k < INT_LINES; k++) begin
                r_line_cnt[k] <= '0;
            end
        end else if (s1_adv && r_s1_inst_ok) begin
            r_cfg[r_s1_inst] <= n_cfg;
            r_evt[r_s1_inst] <= n_evt;
            r_ien[r_s1_inst] <= n_ien;
            for (int k = 0; k < INT_LINES; k++) begin
                r_line_cnt[k] <= n_line_cnt[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_rdata <= n_out_rdata;
            r_out_err   <= acc_err;
            r_out_irq   <= n_out_irq;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_rdata;
    assign o_rsp.access_error = r_out_err;
    assign o_rsp.irq_lines    = r_out_irq;

`ifndef NO_ASSERTIONS
    // An accepted request is held in the request register on the next cycle.
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted request not captured");

    // No request is taken during the message RAM sweep.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_accept)
        else $error("request accepted while clearing message RAM");

    // A rejected access never returns data.
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.access_error) |-> (o_rsp.read_data == '0))
        else $error("access error with nonzero read data");

    // A response waiting on a stall is not overwritten.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_rdata) &&
                                           $stable(r_out_irq)))
        else $error("stalled response changed");
`endif

endmodule
